// File: rtl/multi_queue_byte_fifo_assert.svh
// Assertion helpers included by rtl/mqbf_ctrl.sv.
`ifndef MULTI_QUEUE_BYTE_FIFO_ASSERT_SVH
`define MULTI_QUEUE_BYTE_FIFO_ASSERT_SVH

// Same-cycle implication.
`define MQBF_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MQBF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mqbf_pkg.sv
package mqbf_pkg;

  localparam int SEL_FIELD_W = 5;
  localparam int SEL_CODES   = 2 ** SEL_FIELD_W;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR,
    ST_EXEC,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic rd_move;
  } status_t;

endpackage

// File: rtl/multi_queue_byte_fifo.sv
// Bank of NUM_PIPES circular byte queues, PIPE_DEPTH slots each (one slot kept
// free, so a queue holds PIPE_DEPTH-1 bytes). Each input item reads or writes
// one byte on the selected queue; each item yields exactly one result with the
// byte read (0 unless a read moved data), a moved flag, and the saturating
// byte count of the current call, cleared after an item with tlast set.
// One item is handled at a time: the states PTR (pointer memory read), EXEC
// and, for a read that moves a byte, FETCH (byte memory read) lead to SEND,
// and the next item is accepted the cycle after the result is taken. The
// pointer memory read and the byte memory read are both registered. Pointer
// state is cleared by reset at once; no clearing pass is needed.
module multi_queue_byte_fifo #(
  parameter int NUM_PIPES  = 32,
  parameter int PIPE_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] pipe_sel, [12:5] write_byte, rest zero
  input  logic [mqbf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  logic                               s_axis_tuser,
  // call_end
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] read_byte, [19:8] call_count, rest zero
  output logic [mqbf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] moved
  output logic                               m_axis_tuser
);

  mqbf_pkg::cmd_t              cmd;
  mqbf_pkg::status_t           status;
  logic [mqbf_pkg::BYTE_W-1:0] read_byte;
  logic [mqbf_pkg::CNT_W-1:0]  call_count;

  mqbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .status  (status)
  );

  mqbf_dp #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .action     (s_axis_tuser),
    .pipe_sel   (s_axis_tdata[mqbf_pkg::SEL_FIELD_W-1:0]),
    .write_byte (s_axis_tdata[mqbf_pkg::SEL_FIELD_W +: mqbf_pkg::BYTE_W]),
    .call_end   (s_axis_tlast),
    .read_byte  (read_byte),
    .moved      (m_axis_tuser),
    .call_count (call_count)
  );

  assign m_axis_tdata = {
    {(mqbf_pkg::OUT_DATA_W - mqbf_pkg::CNT_W - mqbf_pkg::BYTE_W){1'b0}},
    call_count,
    read_byte
  };

endmodule

// File: rtl/mqbf_ram.sv
module mqbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mqbf_ctrl.sv
module mqbf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  output mqbf_pkg::cmd_t    cmd,
  input  mqbf_pkg::status_t status
);

  mqbf_pkg::state_t state;
  mqbf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mqbf_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = mqbf_pkg::ST_PTR;
        end
      end
      mqbf_pkg::ST_PTR: begin
        state_next = mqbf_pkg::ST_EXEC;
      end
      mqbf_pkg::ST_EXEC: begin
        state_next = status.rd_move ? mqbf_pkg::ST_FETCH : mqbf_pkg::ST_SEND;
      end
      mqbf_pkg::ST_FETCH: begin
        state_next = mqbf_pkg::ST_SEND;
      end
      mqbf_pkg::ST_SEND: begin
        if (m_ready) begin
          state_next = mqbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mqbf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready       = (state == mqbf_pkg::ST_IDLE);
    m_valid       = (state == mqbf_pkg::ST_SEND);
    cmd.latch_in  = (state == mqbf_pkg::ST_IDLE) && s_valid;
    cmd.exec      = (state == mqbf_pkg::ST_EXEC);
    cmd.load_byte = (state == mqbf_pkg::ST_FETCH);
  end

`include "multi_queue_byte_fifo_assert.svh"

  `MQBF_CHECK_NEXT(a_accept_ptr, s_valid && s_ready, state == mqbf_pkg::ST_PTR, "accept did not start pointer read")
  `MQBF_CHECK_NEXT(a_exec_next, state == mqbf_pkg::ST_EXEC, state == mqbf_pkg::ST_FETCH || state == mqbf_pkg::ST_SEND, "bad state after exec")
  `MQBF_CHECK_NOW(a_fetch_read, state == mqbf_pkg::ST_FETCH, $past(status.rd_move), "byte fetch without a read move")
  `MQBF_CHECK_NEXT(a_send_hold, m_valid && !m_ready, state == mqbf_pkg::ST_SEND, "result dropped while stalled")

endmodule

// File: rtl/mqbf_dp.sv
module mqbf_dp #(
  parameter int NUM_PIPES  = 32,
  parameter int PIPE_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mqbf_pkg::cmd_t                       cmd,
  output mqbf_pkg::status_t                    status,
  input  logic                                 action,
  input  logic [mqbf_pkg::SEL_FIELD_W-1:0]     pipe_sel,
  input  logic [mqbf_pkg::BYTE_W-1:0]          write_byte,
  input  logic                                 call_end,
  output logic [mqbf_pkg::BYTE_W-1:0]          read_byte,
  output logic                                 moved,
  output logic [mqbf_pkg::CNT_W-1:0]           call_count
);

  localparam int PW     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int AW     = $clog2(PIPE_DEPTH);
  localparam int BDEPTH = NUM_PIPES * (2 ** AW);
  localparam int BA_W   = $clog2(BDEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(PIPE_DEPTH - 1);

  logic [PW-1:0] sel_lut [mqbf_pkg::SEL_CODES];

  genvar gi;
  generate
    for (gi = 0; gi < mqbf_pkg::SEL_CODES; gi++) begin : g_sel
      assign sel_lut[gi] = PW'(gi % NUM_PIPES);
    end
  endgenerate

  logic                              action_q;
  logic [PW-1:0]                     sel_q;
  logic [mqbf_pkg::BYTE_W-1:0]       byte_q;
  logic                              last_q;
  logic [mqbf_pkg::CNT_W-1:0]        cnt;
  logic [NUM_PIPES-1:0]              ptr_valid;

  logic [2*AW-1:0]                   ptr_q;
  logic [2*AW-1:0]                   ptr_wdata;
  logic [mqbf_pkg::BYTE_W-1:0]       byte_rd;

  logic                              pv;
  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     rp;
  logic [AW-1:0]                     wp_inc;
  logic [AW-1:0]                     rp_inc;
  logic                              full;
  logic                              empty;
  logic                              wr_move;
  logic                              rd_move;
  logic                              moved_w;
  logic [mqbf_pkg::CNT_W-1:0]        cnt_inc;

  always_comb begin
    pv      = ptr_valid[sel_q];
    wp      = pv ? ptr_q[2*AW-1:AW] : '0;
    rp      = pv ? ptr_q[AW-1:0] : '0;
    wp_inc  = (wp == LAST_SLOT) ? '0 : wp + AW'(1);
    rp_inc  = (rp == LAST_SLOT) ? '0 : rp + AW'(1);
    full    = (wp_inc == rp);
    empty   = (wp == rp);
    wr_move = (action_q == mqbf_pkg::ACT_WRITE) && !full;
    rd_move = (action_q == mqbf_pkg::ACT_READ) && !empty;
    moved_w = wr_move || rd_move;
    cnt_inc = (moved_w && (cnt != mqbf_pkg::CNT_MAX)) ? cnt + mqbf_pkg::CNT_W'(1) : cnt;
    ptr_wdata = {(wr_move ? wp_inc : wp), (rd_move ? rp_inc : rp)};
    status.rd_move = rd_move;
  end

  mqbf_ram #(
    .WIDTH (2 * AW),
    .DEPTH (NUM_PIPES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (cmd.exec && moved_w),
    .waddr (sel_q),
    .wdata (ptr_wdata),
    .raddr (sel_q),
    .rdata (ptr_q)
  );

  mqbf_ram #(
    .WIDTH (mqbf_pkg::BYTE_W),
    .DEPTH (BDEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (cmd.exec && wr_move),
    .waddr (BA_W'({sel_q, wp})),
    .wdata (byte_q),
    .raddr (BA_W'({sel_q, rp})),
    .rdata (byte_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ptr_valid <= '0;
    end else if (cmd.exec) begin
      cnt <= last_q ? '0 : cnt_inc;
      if (moved_w) begin
        ptr_valid[sel_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_q <= action;
      sel_q    <= sel_lut[pipe_sel];
      byte_q   <= write_byte;
      last_q   <= call_end;
    end
    if (cmd.exec) begin
      read_byte  <= '0;
      moved      <= moved_w;
      call_count <= cnt_inc;
    end
    if (cmd.load_byte) begin
      read_byte <= byte_rd;
    end
  end

endmodule
